// File: hw/rtl/lffe_pkg.sv
// Shared types and constants for the lidar frame field extractor.
// Used by the core and by its port checker; depends on nothing else.

package lffe_pkg;

   // One more than the longest frame kept, in stored bytes; the byte counter is sized from it.
   localparam int unsigned MAX_FRAME_LEN = 64;
   localparam int unsigned COUNT_W       = $clog2(MAX_FRAME_LEN + 1);

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_BYTE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIELD_SEPARATOR = 1'd1;

   // Reset values of the registers.
   localparam logic [7:0] START_BYTE_RESET      = 8'h4D;
   localparam logic [7:0] FIELD_SEPARATOR_RESET = 8'h2C;

   // Line characters.
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_PLUS  = 8'h2B;
   localparam logic [7:0] BYTE_MINUS = 8'h2D;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;

   // Field counter codes; the top code marks text ended by a NUL byte.
   localparam logic [1:0] FIELDS_NONE    = 2'd0;
   localparam logic [1:0] FIELDS_SECOND  = 2'd2;
   localparam logic [1:0] FIELDS_NUL_END = 2'd3;

   // Input action codes.
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   // Magnitude saturation points.
   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;

   // Number parser phase.
   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

endpackage

// File: hw/rtl/lidar_frame_field_extractor_core.sv
// Lidar frame receiver core: frames UART bytes and parses the second field.
// Depends on lffe_pkg.

// Each word on the req_ channel is either a received line byte (action 0)
// or a read request (action 1). Bytes are ignored until the start byte is
// seen; the frame then collects until CR LF, while the second
// separator-delimited field is parsed like C atoi and saturated to int32.
// A bad terminator or an overlong frame drops the frame. Bytes after a
// finished frame are ignored until a read takes it. Every read yields one rsp_
// word: ready_res 1 and the value (0 if the field is missing), or ready_res 0
// and -1 when no frame is finished. One word is taken every cycle: each word
// is handled in the cycle it is accepted by the per-byte update logic, whose
// longest path is the times-ten accumulate of the magnitude. A result waits
// in the output register; req_ready drops only while that register holds a
// word that rsp_ready has not taken. There is no clearing pass after reset.

module lidar_frame_field_extractor_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ready_res,
   output logic signed [31:0]              rsp_value,
   input  logic                            csr_write_en,
   input  logic [lffe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data
);

   localparam int unsigned CW = lffe_pkg::COUNT_W;

   // Configuration registers.
   logic [7:0] start_byte_ff, field_sep_ff;

   // Frame and parser state.
   logic                  armed_ff, armed_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  cr_seen_ff, cr_seen_in;
   logic                  done_ff, done_in;
   logic [1:0]            fields_ff, fields_in;
   logic                  inside_ff, inside_in;
   lffe_pkg::phase_type   phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           mag_ff, mag_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_res_ff, rsp_res_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;

   logic                  accept;
   logic                  is_digit, is_blank;
   logic [35:0]           mag_next;
   logic [31:0]           mag_acc;
   logic [31:0]           result_value;

   // A word is taken whenever the output register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Character classes of the incoming byte.
   assign is_digit = (req_rx_byte >= lffe_pkg::BYTE_ZERO) &&
                     (req_rx_byte <= lffe_pkg::BYTE_NINE);
   assign is_blank = (req_rx_byte == lffe_pkg::BYTE_SPACE) ||
                     ((req_rx_byte >= lffe_pkg::BYTE_TAB) &&
                      (req_rx_byte <= lffe_pkg::BYTE_CR));

   // Times ten plus digit, saturated at 2^31.
   assign mag_next = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1) +
                     {32'd0, req_rx_byte[3:0]};
   assign mag_acc  = (mag_next > {4'd0, lffe_pkg::MAG_LIMIT}) ?
                     lffe_pkg::MAG_LIMIT : mag_next[31:0];

   // Value returned by a read of a finished frame.
   always_comb begin
      if (fields_ff != lffe_pkg::FIELDS_SECOND) begin
         result_value = '0;
      end else if (neg_ff) begin
         result_value = 32'd0 - mag_ff;
      end else if (mag_ff > lffe_pkg::INT_MAX) begin
         result_value = lffe_pkg::INT_MAX;
      end else begin
         result_value = mag_ff;
      end
   end

   // Per-word state update.
   always_comb begin
      logic       go;
      logic [1:0] fields_v;
      armed_in   = armed_ff;
      count_in   = count_ff;
      cr_seen_in = cr_seen_ff;
      done_in    = done_ff;
      fields_in  = fields_ff;
      inside_in  = inside_ff;
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      go         = 1'b0;
      fields_v   = fields_ff;

      if (accept && (req_action == lffe_pkg::ACTION_READ)) begin
         // A read of a finished frame clears the frame but keeps armed.
         if (done_ff) begin
            count_in   = '0;
            cr_seen_in = 1'b0;
            done_in    = 1'b0;
            fields_in  = lffe_pkg::FIELDS_NONE;
            inside_in  = 1'b0;
            phase_in   = lffe_pkg::PHASE_SKIP;
            neg_in     = 1'b0;
            mag_in     = '0;
         end
      end else if (accept) begin
         if (req_rx_byte == start_byte_ff) begin
            armed_in = 1'b1;
         end
         if (armed_in && !done_ff) begin
            if (cr_seen_ff) begin
               // Terminator: LF finishes the frame, anything else drops it.
               armed_in = 1'b0;
               if (req_rx_byte == lffe_pkg::BYTE_LF) begin
                  done_in = 1'b1;
               end else begin
                  count_in   = '0;
                  cr_seen_in = 1'b0;
                  fields_in  = lffe_pkg::FIELDS_NONE;
                  inside_in  = 1'b0;
                  phase_in   = lffe_pkg::PHASE_SKIP;
                  neg_in     = 1'b0;
                  mag_in     = '0;
               end
            end else if (req_rx_byte == lffe_pkg::BYTE_CR) begin
               cr_seen_in = 1'b1;
            end else begin
               // Field tracking; a NUL byte ends the text for parsing.
               if (fields_ff != lffe_pkg::FIELDS_NUL_END) begin
                  if (req_rx_byte == lffe_pkg::BYTE_NUL) begin
                     if (fields_ff < lffe_pkg::FIELDS_SECOND) begin
                        fields_in = lffe_pkg::FIELDS_NUL_END;
                     end else begin
                        phase_in = lffe_pkg::PHASE_DONE;
                     end
                  end else if ((field_sep_ff != lffe_pkg::BYTE_NUL) &&
                               (req_rx_byte == field_sep_ff)) begin
                     if (inside_ff && (fields_ff == lffe_pkg::FIELDS_SECOND) &&
                         (phase_ff != lffe_pkg::PHASE_DONE)) begin
                        phase_in = lffe_pkg::PHASE_DONE;
                     end
                     inside_in = 1'b0;
                  end else begin
                     go = 1'b1;
                     if (!inside_ff) begin
                        if (fields_ff >= lffe_pkg::FIELDS_SECOND) begin
                           go = 1'b0;
                        end else begin
                           fields_v  = fields_ff + 2'd1;
                           fields_in = fields_v;
                           inside_in = 1'b1;
                        end
                     end
                  end
               end

               // Number parser runs on bytes of the second field.
               if (go && (fields_v == lffe_pkg::FIELDS_SECOND)) begin
                  unique case (phase_ff)
                     lffe_pkg::PHASE_SKIP: begin
                        if (is_blank) begin
                           phase_in = lffe_pkg::PHASE_SKIP;
                        end else if ((req_rx_byte == lffe_pkg::BYTE_PLUS) ||
                                     (req_rx_byte == lffe_pkg::BYTE_MINUS)) begin
                           neg_in   = (req_rx_byte == lffe_pkg::BYTE_MINUS);
                           phase_in = lffe_pkg::PHASE_DIGITS;
                        end else if (!is_digit) begin
                           phase_in = lffe_pkg::PHASE_DONE;
                        end else begin
                           phase_in = lffe_pkg::PHASE_DIGITS;
                           mag_in   = mag_acc;
                        end
                     end
                     lffe_pkg::PHASE_DIGITS: begin
                        if (!is_digit) begin
                           phase_in = lffe_pkg::PHASE_DONE;
                        end else begin
                           mag_in = mag_acc;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end

               // Length check drops a frame that grows too long.
               count_in = count_ff + CW'(1);
               if (count_in > CW'(lffe_pkg::MAX_FRAME_LEN - 1)) begin
                  armed_in   = 1'b0;
                  count_in   = '0;
                  cr_seen_in = 1'b0;
                  done_in    = 1'b0;
                  fields_in  = lffe_pkg::FIELDS_NONE;
                  inside_in  = 1'b0;
                  phase_in   = lffe_pkg::PHASE_SKIP;
                  neg_in     = 1'b0;
                  mag_in     = '0;
               end
            end
         end
      end
   end

   // Output register: loaded by a read, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_value_in = rsp_value_ff;
      if (accept && (req_action == lffe_pkg::ACTION_READ)) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = done_ff;
         rsp_value_in = done_ff ? result_value : '1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= lffe_pkg::START_BYTE_RESET;
         field_sep_ff  <= lffe_pkg::FIELD_SEPARATOR_RESET;
         armed_ff      <= 1'b0;
         count_ff      <= '0;
         cr_seen_ff    <= 1'b0;
         done_ff       <= 1'b0;
         fields_ff     <= lffe_pkg::FIELDS_NONE;
         inside_ff     <= 1'b0;
         phase_ff      <= lffe_pkg::PHASE_SKIP;
         neg_ff        <= 1'b0;
         mag_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               lffe_pkg::REG_START_BYTE:      start_byte_ff <= csr_data;
               lffe_pkg::REG_FIELD_SEPARATOR: field_sep_ff  <= csr_data;
               default:                       start_byte_ff <= start_byte_ff;
            endcase
         end
         armed_ff     <= armed_in;
         count_ff     <= count_in;
         cr_seen_ff   <= cr_seen_in;
         done_ff      <= done_in;
         fields_ff    <= fields_in;
         inside_ff    <= inside_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_res_ff   <= rsp_res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ready_res = rsp_res_ff;
   assign rsp_value     = $signed(rsp_value_ff);

endmodule

// File: hw/rtl/lffe_checker.sv
// Port-level checks for the lidar frame field extractor core, with its bind.
// Depends on lffe_pkg and lidar_frame_field_extractor_core.

module lffe_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_action,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_ready_res,
   input logic signed [31:0]               rsp_value
);

   // A stalled result word holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_value) && $stable(rsp_ready_res)))
      else $error("stalled result word changed");

   // A not-ready answer always carries -1.
   a_not_ready_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready_res) |-> (rsp_value == -32'sd1))
      else $error("not-ready answer without -1");

   // Every accepted read produces a result word in the next cycle.
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && req_ready && (req_action == lffe_pkg::ACTION_READ))
         |=> rsp_valid)
      else $error("read accepted without a result word");

   // No word is taken while a result waits and is not being drained.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("word accepted over a stalled result");

endmodule

bind lidar_frame_field_extractor_core lffe_checker u_lffe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_ready_res (rsp_ready_res),
   .rsp_value     (rsp_value)
);
